/* rtl/core/fplc_pkg.sv */
// Package for the framed packet loader: frame constants, reply codes,
// sequencer state type. No dependencies.
`default_nettype none

package fplc_pkg;

    localparam int unsigned HDR_LEN = 4;

    localparam logic [7:0]  HDR_BYTE0 = 8'hAA;
    localparam logic [7:0]  HDR_BYTE1 = 8'hBB;
    localparam logic [7:0]  HDR_BYTE2 = 8'hCC;
    localparam logic [7:0]  HDR_BYTE3 = 8'hDD;

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [7:0]  CODE_ACK  = 8'h06;
    localparam logic [7:0]  CODE_NAK  = 8'h15;

    localparam logic        KIND_WRITE = 1'b0;
    localparam logic        KIND_REPLY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRC,
        ST_RD,
        ST_WR,
        ST_REPLY
    } state_t;

    // expected preamble byte at header position
    function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
        logic [7:0] res;
        case (pos)
            2'd0:    res = HDR_BYTE0;
            2'd1:    res = HDR_BYTE1;
            2'd2:    res = HDR_BYTE2;
            default: res = HDR_BYTE3;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/fplc_rx_if.sv */
// Receive-byte channel: valid/ready handshake with one 8-bit byte.
// No dependencies.
`default_nettype none

interface fplc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/fplc_res_if.sv */
// Result channel: valid/ready handshake carrying kind, address, value, last.
// No dependencies.
`default_nettype none

interface fplc_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] address;
    logic [7:0]  value;
    logic        last;

    modport source (output valid, output kind, output address, output value,
                    output last, input ready);
    modport sink   (input valid, input kind, input address, input value,
                    input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/framed_packet_loader_crc16_core.sv */
// Framed packet loader top level: preamble check, bit-serial CRC-16/XMODEM,
// payload buffer and write/reply sequencer. Uses fplc_pkg, fplc_rx_if, fplc_res_if.
`default_nettype none

// Received bytes are grouped into frames of PAYLOAD_BYTES + 6 bytes: preamble
// AA BB CC DD, the payload, then a CRC-16/XMODEM (poly 0x1021, init 0, MSB
// first) sent high byte first. When a frame ends with a good preamble and a
// matching CRC, the block issues one memory write per payload byte at a
// running 32-bit byte address (wraps modulo 2^32), then an ACK reply (0x06);
// otherwise a single NAK reply (0x15). Reply results carry address 0 and
// last = 1; writes carry last = 0. The CRC is updated by one shared
// shift/xor step per bit of each payload byte. Each write of a good frame
// takes a payload buffer read followed by an output register load, and the
// ACK follows the last write. Output stalls extend the write and reply
// steps. rx.ready is high only while the sequencer is idle. The payload
// buffer has no reset; each entry is written within a frame before it is
// read.
module framed_packet_loader_crc16_core #(
    parameter int unsigned PAYLOAD_BYTES = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    fplc_rx_if.sink     rx,
    fplc_res_if.source  result
);
    import fplc_pkg::*;

    localparam int unsigned FRAME_LEN = PAYLOAD_BYTES + 6;
    localparam int unsigned POS_W     = $clog2(FRAME_LEN);
    localparam int unsigned IDX_W     = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    localparam logic [POS_W-1:0] POS_HDR_END = POS_W'(HDR_LEN);
    localparam logic [POS_W-1:0] POS_PAY_END = POS_W'(HDR_LEN + PAYLOAD_BYTES);
    localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(PAYLOAD_BYTES - 1);

    // control registers
    state_t             state_reg,     state_next;
    logic [POS_W-1:0]   pos_reg,       pos_next;
    logic               pre_good_reg,  pre_good_next;
    logic [15:0]        crc_reg,       crc_next;
    logic [2:0]         bit_cnt_reg,   bit_cnt_next;
    logic [31:0]        addr_reg,      addr_next;
    logic [IDX_W-1:0]   rd_idx_reg,    rd_idx_next;
    logic               out_valid_reg, out_valid_next;

    // payload registers
    logic [7:0]         shift_reg,     shift_next;
    logic [7:0]         crc_hi_reg,    crc_hi_next;
    logic [7:0]         code_reg,      code_next;
    logic               out_kind_reg,  out_kind_next;
    logic [31:0]        out_addr_reg,  out_addr_next;
    logic [7:0]         out_value_reg, out_value_next;
    logic               out_last_reg,  out_last_next;

    // payload buffer
    logic [7:0]         pay_mem [PAYLOAD_BYTES];
    logic [7:0]         rd_data_reg;
    logic               mem_we;
    logic               mem_re;
    logic [POS_W-1:0]   pos_off;
    logic [IDX_W-1:0]   mem_waddr;

    logic               out_free;
    logic               crc_fb;
    logic [7:0]         b;

    assign b         = rx.rx_byte;
    assign pos_off   = pos_reg - POS_HDR_END;
    assign mem_waddr = pos_off[IDX_W-1:0];
    assign out_free  = !out_valid_reg || result.ready;
    assign crc_fb    = crc_reg[15] ^ shift_reg[7];

    assign rx.ready       = (state_reg == ST_IDLE);
    assign result.valid   = out_valid_reg;
    assign result.kind    = out_kind_reg;
    assign result.address = out_addr_reg;
    assign result.value   = out_value_reg;
    assign result.last    = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        pre_good_next  = pre_good_reg;
        crc_next       = crc_reg;
        bit_cnt_next   = bit_cnt_reg;
        addr_next      = addr_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg && !result.ready;
        shift_next     = shift_reg;
        crc_hi_next    = crc_hi_reg;
        code_next      = code_reg;
        out_kind_next  = out_kind_reg;
        out_addr_next  = out_addr_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (rx.valid)
                begin
                    if (pos_reg < POS_HDR_END)
                    begin
                        if (b != hdr_byte(pos_reg[1:0]))
                            pre_good_next = 1'b0;
                        pos_next = pos_reg + POS_W'(1);
                    end
                    else if (pos_reg < POS_PAY_END)
                    begin
                        mem_we       = 1'b1;
                        shift_next   = b;
                        bit_cnt_next = 3'd0;
                        pos_next     = pos_reg + POS_W'(1);
                        state_next   = ST_CRC;
                    end
                    else if (pos_reg == POS_PAY_END)
                    begin
                        crc_hi_next = b;
                        pos_next    = pos_reg + POS_W'(1);
                    end
                    else
                    begin
                        // frame end: check and restart framing
                        pos_next      = '0;
                        pre_good_next = 1'b1;
                        crc_next      = 16'h0000;
                        if (pre_good_reg && ({crc_hi_reg, b} == crc_reg))
                        begin
                            rd_idx_next = '0;
                            state_next  = ST_RD;
                        end
                        else
                        begin
                            code_next  = CODE_NAK;
                            state_next = ST_REPLY;
                        end
                    end
                end
            end

            ST_CRC:
            begin
                // one CRC bit per cycle
                crc_next     = {crc_reg[14:0], 1'b0} ^ (crc_fb ? CRC_POLY : 16'h0000);
                shift_next   = {shift_reg[6:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7)
                    state_next = ST_IDLE;
            end

            ST_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_WR;
            end

            ST_WR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_WRITE;
                    out_addr_next  = addr_reg;
                    out_value_next = rd_data_reg;
                    out_last_next  = 1'b0;
                    addr_next      = addr_reg + 32'd1;
                    if (rd_idx_reg == IDX_LAST)
                    begin
                        code_next  = CODE_ACK;
                        state_next = ST_REPLY;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                        state_next  = ST_RD;
                    end
                end
            end

            ST_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_REPLY;
                    out_addr_next  = 32'd0;
                    out_value_next = code_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            pre_good_reg  <= 1'b1;
            crc_reg       <= 16'h0000;
            bit_cnt_reg   <= 3'd0;
            addr_reg      <= 32'd0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            pre_good_reg  <= pre_good_next;
            crc_reg       <= crc_next;
            bit_cnt_reg   <= bit_cnt_next;
            addr_reg      <= addr_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg     <= shift_next;
        crc_hi_reg    <= crc_hi_next;
        code_reg      <= code_next;
        out_kind_reg  <= out_kind_next;
        out_addr_reg  <= out_addr_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    // payload buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            pay_mem[mem_waddr] <= b;
        if (mem_re)
            rd_data_reg <= pay_mem[rd_idx_reg];
    end

endmodule

`default_nettype wire

/* bench/tb_framed_packet_loader_crc16_core.sv */
// Testbench for framed_packet_loader_crc16_core: drives received bytes in whole frames,
// predicts memory writes and ACK/NAK replies, and checks every result transfer.
// Depends on fplc_pkg, fplc_rx_if, fplc_res_if and the core RTL.
`timescale 1ns / 100ps

module tb_framed_packet_loader_crc16_core;

    import fplc_pkg::*;

    localparam int unsigned PAYLOAD_BYTES = 32;
    localparam int unsigned FRAME_LEN     = PAYLOAD_BYTES + HDR_LEN + 2;
    // generous: many times the slowest expected run with full stalls
    localparam int unsigned CYCLE_LIMIT   = 400000;
    // after the last expected transfer, long enough for a stray write burst
    localparam int unsigned END_SETTLE    = 4 * PAYLOAD_BYTES + 40;
    localparam logic [31:0] PREAMBLE      = {HDR_BYTE0, HDR_BYTE1, HDR_BYTE2, HDR_BYTE3};

    typedef struct packed {
        logic        kind;
        logic [31:0] address;
        logic [7:0]  value;
        logic        last;
    } loader_out_t;

    // how a frame is corrupted before it goes on the wire
    typedef enum {
        FR_GOOD,
        FR_BAD_HDR,
        FR_BAD_CRC,
        FR_NOISE
    } frame_kind_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sink_hold = 1'b0;
    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    int unsigned cycle_count = 0;
    int unsigned err_count = 0;

    // predictor state: mirrors the frame parser of the core
    int unsigned frame_pos = 0;
    logic        hdr_ok = 1'b1;
    logic [15:0] crc_acc = '0;
    logic [7:0]  crc_hi = '0;
    logic [31:0] next_addr = '0;
    logic [7:0]  pay_buf [PAYLOAD_BYTES];

    // writes and replies still owed by the core, oldest first
    loader_out_t pending_writes_replies [$];

    fplc_rx_if  rx_ch ();
    fplc_res_if res_ch ();

    framed_packet_loader_crc16_core #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch)
    );

    always #2 clk = ~clk;

    // CRC-16/XMODEM, one byte, MSB first
    function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        int k;
        r = c ^ {b, 8'h00};
        for (k = 0; k < 8; k++)
        begin
            if (r[15])
                r = (r << 1) ^ CRC_POLY;
            else
                r = r << 1;
        end
        return r;
    endfunction

    // Advances the frame parser by one accepted byte; on the closing CRC byte
    // queues either the whole write burst plus ACK, or a lone NAK.
    function automatic void predict_loader_bytes(input logic [7:0] b);
        loader_out_t o;
        int unsigned i;
        if (frame_pos < HDR_LEN)
        begin
            if (b != PREAMBLE[31 - 8 * frame_pos -: 8])
                hdr_ok = 1'b0;
            frame_pos++;
        end
        else if (frame_pos < HDR_LEN + PAYLOAD_BYTES)
        begin
            pay_buf[frame_pos - HDR_LEN] = b;
            crc_acc = crc16_next(crc_acc, b);
            frame_pos++;
        end
        else if (frame_pos == HDR_LEN + PAYLOAD_BYTES)
        begin
            crc_hi = b;
            frame_pos++;
        end
        else
        begin
            o.address = '0;
            o.last = 1'b1;
            o.kind = KIND_REPLY;
            o.value = CODE_NAK;
            if (hdr_ok && {crc_hi, b} == crc_acc)
            begin
                for (i = 0; i < PAYLOAD_BYTES; i++)
                begin
                    // address wraps mod 2^32 by the vector width
                    pending_writes_replies.push_back({KIND_WRITE, next_addr, pay_buf[i], 1'b0});
                    next_addr = next_addr + 32'd1;
                end
                o.value = CODE_ACK;
            end
            pending_writes_replies.push_back(o);
            frame_pos = 0;
            hdr_ok = 1'b1;
            crc_acc = '0;
        end
    endfunction

    // One rx transfer. valid stays high into the next call unless that call
    // idles first, so back-to-back bytes never toggle valid within a step.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        predict_loader_bytes(b);
    endtask

    // Builds one full-length frame so the parser stays aligned; corrupted
    // kinds keep the length and only spoil the preamble, the CRC or all of it.
    task automatic send_frame(input frame_kind_t kind, input bit rand_fill,
                              input logic [7:0] fill);
        logic [7:0]  fr [FRAME_LEN];
        logic [15:0] crc;
        int unsigned k;
        crc = '0;
        for (k = 0; k < HDR_LEN; k++)
            fr[k] = PREAMBLE[31 - 8 * k -: 8];
        for (k = 0; k < PAYLOAD_BYTES; k++)
        begin
            fr[HDR_LEN + k] = rand_fill ? 8'($urandom) : fill;
            crc = crc16_next(crc, fr[HDR_LEN + k]);
        end
        case (kind)
            FR_BAD_HDR:
            begin
                k = $urandom_range(HDR_LEN - 1);
                fr[k] = fr[k] ^ 8'($urandom_range(255, 1));
            end
            FR_BAD_CRC:
                crc = crc ^ 16'($urandom_range(65535, 1));
            default:
                ;
        endcase
        fr[FRAME_LEN - 2] = crc[15:8];
        fr[FRAME_LEN - 1] = crc[7:0];
        if (kind == FR_NOISE)
        begin
            for (k = 0; k < FRAME_LEN; k++)
                fr[k] = 8'($urandom);
        end
        for (k = 0; k < FRAME_LEN; k++)
            send_byte(fr[k]);
    endtask

    task automatic rx_quiet();
        rx_ch.valid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        while (pending_writes_replies.size() != 0)
            @(posedge clk);
    endtask

    // Forces result.ready low through sink_hold; runs in its own forked process.
    task automatic hold_result_ready(input int unsigned n);
        sink_hold <= 1'b1;
        repeat (n) @(posedge clk);
        sink_hold <= 1'b0;
    endtask

    task automatic set_idling(input int unsigned src_pct, input int unsigned snk_pct);
        src_idle_pct <= src_pct;
        snk_stall_pct <= snk_pct;
    endtask

    // Extremes of the payload (all 00 gives CRC 0000, all FF), a spoiled
    // preamble with a valid CRC, and a CRC mismatch after a clean preamble.
    task automatic test_directed_frames();
        set_idling(0, 0);
        send_frame(FR_GOOD, 1'b0, 8'h00);
        send_frame(FR_GOOD, 1'b0, 8'hFF);
        send_frame(FR_BAD_HDR, 1'b1, 8'h00);
        send_frame(FR_BAD_CRC, 1'b1, 8'h00);
        rx_quiet();
        wait_for_drain();
    endtask

    task automatic run_random_frames(input int unsigned n_frames);
        int unsigned f;
        int unsigned pick;
        for (f = 0; f < n_frames; f++)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                send_frame(FR_GOOD, 1'b1, 8'h00);
            else if (pick < 77)
                send_frame(FR_BAD_HDR, 1'b1, 8'h00);
            else if (pick < 89)
                send_frame(FR_BAD_CRC, 1'b1, 8'h00);
            else
                send_frame(FR_NOISE, 1'b1, 8'h00);
        end
    endtask

    // Mostly well-formed frames with random payloads; between phases the
    // sender stops until every write and reply has been taken.
    task automatic test_random_traffic();
        set_idling(0, 0);
        run_random_frames(2);
        rx_quiet();
        wait_for_drain();
        set_idling(67, 0);
        run_random_frames(1);
        rx_quiet();
        wait_for_drain();
        set_idling(0, 67);
        run_random_frames(2);
        rx_quiet();
        wait_for_drain();
        set_idling(32, 32);
        run_random_frames(1);
        rx_quiet();
        wait_for_drain();
    endtask

    // Long receiver hold spanning a write burst: the core must stall rx while
    // the sender keeps offering the next frame.
    task automatic test_output_backpressure();
        set_idling(0, 0);
        fork
            hold_result_ready(FRAME_LEN * 12 + 200);
        join_none
        send_frame(FR_GOOD, 1'b1, 8'h00);
        send_frame(FR_GOOD, 1'b1, 8'h00);
        send_frame(FR_BAD_CRC, 1'b1, 8'h00);
        rx_quiet();
        wait_for_drain();
    endtask

    // Result checker: every transfer is matched against the oldest prediction.
    always @(posedge clk)
    begin
        loader_out_t want;
        if (res_ch.valid && res_ch.ready)
        begin
            if (pending_writes_replies.size() == 0)
            begin
                err_count++;
                $display("%0t unexpected result: kind=%0b addr=%h value=%h last=%0b",
                         $time, res_ch.kind, res_ch.address, res_ch.value, res_ch.last);
            end
            else
            begin
                want = pending_writes_replies.pop_front();
                if (res_ch.kind !== want.kind)
                begin
                    err_count++;
                    $display("%0t kind mismatch: expected %0b actual %0b",
                             $time, want.kind, res_ch.kind);
                end
                if (res_ch.address !== want.address)
                begin
                    err_count++;
                    $display("%0t address mismatch: expected %h actual %h",
                             $time, want.address, res_ch.address);
                end
                if (res_ch.value !== want.value)
                begin
                    err_count++;
                    $display("%0t value mismatch: expected %h actual %h",
                             $time, want.value, res_ch.value);
                end
                if (res_ch.last !== want.last)
                begin
                    err_count++;
                    $display("%0t last mismatch: expected %0b actual %0b",
                             $time, want.last, res_ch.last);
                end
            end
        end
    end

    // Receiver side: random stalls, forced low during a hold.
    always @(posedge clk)
        res_ch.ready <= !sink_hold && ($urandom_range(99) >= snk_stall_pct);

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Address wrap at 2^32 is out of reach: the write address only resets to
    // zero and advances by one frame of writes at a time.
    initial
    begin
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_random_traffic();
        test_output_backpressure();
        wait_for_drain();
        repeat (END_SETTLE) @(posedge clk);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
